@@ src/btr_pkg.sv @@
// Shared types and codes for the block trace ring.
package btr_pkg;

  typedef enum logic [1:0] {
    ACT_WATCH = 2'd0,
    ACT_POP   = 2'd1,
    ACT_RATE  = 2'd2,
    ACT_FLUSH = 2'd3
  } act_t;

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_NUM  = 2'd1;
  localparam logic [1:0] KIND_STOP = 2'd2;

  localparam logic [1:0] RATE_OFF  = 2'd0;
  localparam logic [1:0] RATE_LOW  = 2'd1;
  localparam logic [1:0] RATE_HIGH = 2'd2;

  localparam logic [1:0] OUT_IGN  = 2'd0;
  localparam logic [1:0] OUT_DATA = 2'd1;
  localparam logic [1:0] OUT_NUM  = 2'd2;
  localparam logic [1:0] OUT_STOP = 2'd3;

  localparam int BLK_W = 56;

  // Result item.
  typedef struct packed {
    logic [8:0]       queued_data;
    logic [12:0]      queued_packets;
    logic [1:0]       rate_now;
    logic [1:0]       watch_outcome;
    logic [7:0]       payload_slot;
    logic [BLK_W-1:0] packet_block;
    logic [1:0]       packet_kind;
    logic             packet_valid;
  } res_t;

endpackage

@@ src/btr_ring_mem.sv @@
// Ring entry memory: one write port, one registered read port.
module btr_ring_mem #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12,
  parameter int DW    = 66
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);
  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ src/btr_slot_map.sv @@
// Payload slot bitmap: free by index, take with rotating word hand.
module btr_slot_map #(
  parameter int SLOTS = 256,
  parameter int SW    = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          free_en,
  input  logic [SW-1:0] free_slot,
  input  logic          take_en,
  output logic          take_ok,
  output logic [SW-1:0] take_slot,
  output logic          busy
);
  import btr_pkg::*;
  localparam int WORDS = (SLOTS + 31) / 32;
  localparam int WW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int SWP   = SW + 5;

  logic [31:0]   map_r [WORDS];
  logic [WW-1:0] hand_r;
  logic [WW-1:0] scan_r, scan_nxt;
  logic [WW:0]   tried_r;
  logic          scan_act_r;
  logic          init_r;
  logic [WW-1:0] init_idx_r;
  logic [4:0]    low_bit;
  logic          word_nz;
  logic [31:0]   cur_w;

  assign busy  = scan_act_r | init_r;
  assign cur_w = map_r[scan_r];
  assign word_nz = cur_w != 32'd0;
  assign scan_nxt = (scan_r == WW'(WORDS - 1)) ? '0 : scan_r + 1'b1;

  always_comb begin
    low_bit = '0;
    for (int b = 31; b >= 0; b--) begin
      if (cur_w[b]) low_bit = 5'(b);
    end
  end

  function automatic logic [31:0] init_word(input int i);
    int left;
    left = SLOTS - i * 32;
    if (left >= 32) return 32'hffff_ffff;
    return (32'd1 << left) - 32'd1;
  endfunction

  assign take_ok   = scan_act_r & word_nz;
  assign take_slot = SW'({SWP'(scan_r), 5'd0} | SWP'(low_bit));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hand_r     <= '0;
      scan_act_r <= 1'b0;
      tried_r    <= '0;
      init_r     <= 1'b1;
      init_idx_r <= '0;
      scan_r     <= '0;
    end else if (init_r) begin
      map_r[init_idx_r] <= init_word(int'(init_idx_r));
      init_idx_r <= init_idx_r + 1'b1;
      if (init_idx_r == WW'(WORDS - 1)) init_r <= 1'b0;
    end else begin
      if (free_en && 32'(free_slot) < SLOTS) begin
        map_r[free_slot[SW-1:5]] <= map_r[free_slot[SW-1:5]] | (32'd1 << free_slot[4:0]);
      end
      if (take_en && !scan_act_r) begin
        scan_act_r <= 1'b1;
        scan_r     <= hand_r;
        tried_r    <= '0;
      end else if (scan_act_r) begin
        if (word_nz) begin
          map_r[scan_r] <= cur_w & ~(32'd1 << low_bit);
          hand_r     <= scan_r;
          scan_act_r <= 1'b0;
        end else if (tried_r == (WW+1)'(WORDS - 1)) begin
          scan_act_r <= 1'b0;
        end else begin
          scan_r  <= scan_nxt;
          tried_r <= tried_r + 1'b1;
        end
      end
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) take_ok |=> !scan_act_r)
    else $error("slot scan did not finish after a take");
endmodule

@@ src/block_trace_ring_with_overload_degrade_unit.sv @@
// Top level: trace ring sequencer with slot allocator and entry memory.
//  channel | dir | fields
//  in_     | in  | tdata: action, block_number, block_count, new_rate
//  out_    | out | tdata: result fields, one transfer per input transfer
// Set rate goes straight to the result; pop reads one entry; flush walks every held entry.
// Watch with data takes a bitmap slot per block, scanning past empty bitmap words;
// numbers only pushes one entry per block; a degrade walk first visits every held entry.
// The unit returns to idle after each result before it takes the next input transfer.
// Reset sweeps the slot bitmap with in_tready low.
// A stalled result holds in the output register; the next transfer is still taken.
module block_trace_ring_with_overload_degrade_unit #(
  parameter int RING_DEPTH    = 4096,
  parameter int PAYLOAD_SLOTS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,  // action[1:0], block_number[57:2], block_count[65:58], new_rate[67:66]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata  // packet_valid, packet_kind, packet_block, payload_slot,
                                 // watch_outcome, rate_now, queued_packets, queued_data
);
  import btr_pkg::*;
  localparam int AW = $clog2(RING_DEPTH);
  localparam int SW = $clog2(PAYLOAD_SLOTS);
  localparam int CW = AW + 1;
  localparam int DW = SW + 1;
  localparam int EW = 2 + BLK_W + SW;

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001, ST_RD = 9'b000000010, ST_POP = 9'b000000100,
    ST_DGR  = 9'b000001000, ST_DGW = 9'b000010000, ST_TAKE = 9'b000100000,
    ST_PUSH = 9'b001000000, ST_FLR = 9'b010000000, ST_OUT = 9'b100000000
  } st_t;

  st_t st_r, st_nxt;
  logic [1:0]       act_r;
  logic [BLK_W-1:0] blk_r;
  logic [7:0]       cnt_r, k_r;
  logic [1:0]       nrate_r, rate_r;
  logic [AW-1:0]    head_r, tail_r, walk_r;
  logic [CW-1:0]    total_r, left_r;
  logic [DW-1:0]    data_r;
  logic [1:0]       outc_r, push_kind_r;
  res_t             res_r, res_nxt;
  res_t             wrk_r;
  logic             ovalid_r;
  logic             out_load;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;
  logic [1:0]    rd_kind;
  logic [BLK_W-1:0] rd_blk;
  logic [SW-1:0] rd_slot;
  logic          free_en, take_en, take_ok, map_busy;
  logic [SW-1:0] free_slot, take_slot;

  assign {rd_slot, rd_blk, rd_kind} = rdata;

  btr_ring_mem #(.DEPTH(RING_DEPTH), .AW(AW), .DW(EW)) u_mem (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );
  btr_slot_map #(.SLOTS(PAYLOAD_SLOTS), .SW(SW)) u_map (
    .clk, .rst_n, .free_en, .free_slot, .take_en, .take_ok, .take_slot, .busy(map_busy)
  );

  function automatic logic [AW-1:0] nxt(input logic [AW-1:0] v);
    return (v == AW'(RING_DEPTH - 1)) ? '0 : v + 1'b1;
  endfunction

  assign in_tready  = (st_r == ST_IDLE) && !map_busy;
  assign out_tvalid = ovalid_r;
  assign out_tdata  = 96'(res_r);
  assign out_load   = (st_r == ST_OUT) && (!ovalid_r || out_tready);
  assign raddr = (st_r == ST_IDLE) ? tail_r : walk_r;
  assign take_en = (st_r == ST_TAKE) && !map_busy && (outc_r == OUT_DATA);

  always_comb begin
    res_nxt = wrk_r;
    res_nxt.watch_outcome  = (act_r == ACT_WATCH) ? outc_r : OUT_IGN;
    res_nxt.rate_now       = rate_r;
    res_nxt.queued_packets = 13'(total_r);
    res_nxt.queued_data    = 9'(data_r);
  end

  always_comb begin
    we = 1'b0; waddr = head_r; wdata = '0; free_en = 1'b0; free_slot = rd_slot;
    unique case (st_r)
      ST_POP: free_en = (rd_kind == KIND_DATA);
      ST_FLR: free_en = (rd_kind == KIND_DATA) && (left_r != '0);
      ST_DGW: begin
        free_en = (rd_kind == KIND_DATA);
        we = free_en; waddr = walk_r;
        wdata = {SW'(0), rd_blk, KIND_NUM};
      end
      ST_PUSH: begin
        we = (total_r < CW'(RING_DEPTH));
        wdata = (push_kind_r == KIND_STOP) ? {SW'(0), BLK_W'(0), KIND_STOP} :
                (take_ok ? {take_slot, blk_r + BLK_W'(k_r), KIND_DATA}
                         : {SW'(0), blk_r + BLK_W'(k_r), KIND_NUM});
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; ovalid_r <= 1'b0; rate_r <= RATE_OFF;
      head_r <= '0; tail_r <= '0; total_r <= '0; data_r <= '0;
    end else begin
      if (out_load) ovalid_r <= 1'b1;
      else if (out_tvalid && out_tready) ovalid_r <= 1'b0;
      unique case (st_r)
        ST_IDLE: if (in_tvalid && in_tready) begin
          act_r <= in_tdata[1:0]; blk_r <= in_tdata[57:2];
          cnt_r <= in_tdata[65:58]; nrate_r <= in_tdata[67:66];
          wrk_r <= '0; outc_r <= OUT_IGN; k_r <= '0;
          walk_r <= tail_r; left_r <= total_r;
          st_r <= ST_RD;
        end
        ST_RD: begin
          unique case (act_t'(act_r))
            ACT_POP: st_r <= (total_r != '0) ? ST_POP : ST_OUT;
            ACT_RATE: begin
              if (nrate_r != 2'd3) rate_r <= nrate_r;
              st_r <= ST_OUT;
            end
            ACT_FLUSH: st_r <= ST_FLR;
            ACT_WATCH: begin
              if (rate_r == RATE_HIGH &&
                  ((DW+1)'(data_r) + (DW+1)'(cnt_r) > (DW+1)'(PAYLOAD_SLOTS))) begin
                rate_r <= RATE_LOW; data_r <= '0;
                if (left_r != '0) st_r <= ST_DGW; else st_r <= ST_TAKE;
              end else begin
                st_r <= ST_TAKE;
              end
            end
          endcase
        end
        ST_POP: begin
          wrk_r.packet_valid <= 1'b1; wrk_r.packet_kind <= rd_kind;
          wrk_r.packet_block <= rd_blk;
          wrk_r.payload_slot <= (rd_kind == KIND_DATA) ? 8'(rd_slot) : 8'd0;
          if (rd_kind == KIND_DATA && data_r != '0) data_r <= data_r - 1'b1;
          tail_r <= nxt(tail_r); total_r <= total_r - 1'b1;
          st_r <= ST_OUT;
        end
        ST_DGR: st_r <= (act_r == ACT_FLUSH) ? ST_FLR : ST_DGW;
        ST_DGW: begin
          walk_r <= nxt(walk_r); left_r <= left_r - 1'b1;
          st_r <= (left_r == CW'(1)) ? ST_TAKE : ST_DGR;
        end
        ST_FLR: begin
          if (left_r == '0) begin
            tail_r <= head_r; total_r <= '0; data_r <= '0; st_r <= ST_OUT;
          end else begin
            walk_r <= nxt(walk_r); left_r <= left_r - 1'b1; st_r <= ST_DGR;
          end
        end
        ST_TAKE: if (!map_busy) begin
          // decide path once, at k = 0
          if (k_r == '0 && outc_r == OUT_IGN) begin
            if (rate_r == RATE_OFF) st_r <= ST_OUT;
            else if (rate_r == RATE_HIGH &&
                     (CW+1)'(total_r) + (CW+1)'(cnt_r) <= (CW+1)'(RING_DEPTH)) begin
              outc_r <= OUT_DATA; push_kind_r <= KIND_DATA;
              st_r <= (cnt_r == '0) ? ST_OUT : ST_TAKE;
            end else if ((CW+1)'(total_r) + (CW+1)'(cnt_r) >= (CW+1)'(RING_DEPTH)) begin
              rate_r <= RATE_OFF; outc_r <= OUT_STOP; push_kind_r <= KIND_STOP;
              st_r <= ST_PUSH;
            end else begin
              outc_r <= OUT_NUM; push_kind_r <= KIND_NUM;
              st_r <= (cnt_r == '0) ? ST_OUT : ST_PUSH;
            end
          end else begin
            st_r <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (push_kind_r != KIND_DATA || !map_busy || take_ok) begin
            if (we) begin
              head_r <= nxt(head_r); total_r <= total_r + 1'b1;
              if (push_kind_r == KIND_DATA && take_ok) data_r <= data_r + 1'b1;
            end
            k_r <= k_r + 1'b1;
            if (push_kind_r == KIND_STOP || k_r + 8'd1 == cnt_r) st_r <= ST_OUT;
            else if (push_kind_r == KIND_DATA) st_r <= ST_TAKE;
          end
        end
        ST_OUT: if (out_load) begin
          res_r <= res_nxt;
          st_r <= ST_IDLE;
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) total_r <= CW'(RING_DEPTH))
    else $error("ring count beyond depth");
  assert property (@(posedge clk) disable iff (!rst_n) 32'(data_r) <= 32'(total_r))
    else $error("data count exceeds ring count");
  assert property (@(posedge clk) disable iff (!rst_n) in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while busy");
endmodule
